[design/pms_pkg.sv]
package pms_pkg;

  typedef enum logic [2:0] {
    MODE_STARTUP   = 3'd0,
    MODE_SWING_UP  = 3'd1,
    MODE_UP_DOWN   = 3'd2,
    MODE_BALANCE   = 3'd3,
    MODE_ARM_CORR  = 3'd4,
    MODE_COMPLIANT = 3'd5,
    MODE_UP_RIGHT  = 3'd6
  } mode_e;

  // Threshold compare results for one sample; aN is |meas N|.
  typedef struct packed {
    logic a1_le20;
    logic a1_ge20;
    logic a1_le15;
    logic a1_ge89;
    logic a1_le91;
    logic a1_le1;
    logic a1_le35;
    logic a1_ge60;
    logic a1_le120;
    logic a1_le_tenth;
    logic a2_le10;
    logic a2_le15;
    logic a2_le1;
    logic a2_ge170;
    logic a3_le1;
    logic a4_le2;
    logic a4_le_0p4;
    logic a4_le20;
    logic a5_le7;
    logic a5_le10;
  } guard_t;

  // Degree thresholds: d * 3.14 / 180 rad, kept as numerator d * 314 over this.
  localparam longint unsigned DegDen = 64'd18000;
  localparam longint unsigned DegNum = 64'd314;

endpackage

[design/pms_in_if.sv]
interface pms_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] meas_one;
  logic signed [DATA_WIDTH-1:0] meas_two;
  logic signed [DATA_WIDTH-1:0] meas_three;
  logic signed [DATA_WIDTH-1:0] meas_four;
  logic signed [DATA_WIDTH-1:0] meas_five;

  modport source (
    output valid, meas_one, meas_two, meas_three, meas_four, meas_five,
    input  ready
  );
  modport sink (
    input  valid, meas_one, meas_two, meas_three, meas_four, meas_five,
    output ready
  );
endinterface

[design/pms_out_if.sv]
interface pms_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] next_mode;

  modport source (
    output valid, next_mode,
    input  ready
  );
  modport sink (
    input  valid, next_mode,
    output ready
  );
endinterface

[design/pendulum_mode_supervisor.sv]
// An accepted item is held in the input register, then its mode result is registered
// in the result/mode register, where it waits while the output is not ready.
// Throughput: one item per cycle; the input register keeps taking items while a
// result waits, and stalls only when both stages are full and the result is not taken.
// Reset: asynchronous, active low; clears both stage valids and sets the mode to startup.
module pendulum_mode_supervisor import pms_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pms_in_if.sink    in_i,
  pms_out_if.source out_o
);

  logic                         s1_valid_q;
  logic signed [DATA_WIDTH-1:0] m1_q, m2_q, m3_q, m4_q, m5_q;
  logic                         out_valid_q;
  mode_e                        mode_q;
  mode_e                        mode_d;
  guard_t                       guard;
  logic                         out_load;
  logic                         in_take;

  // Advance the held item into the result register when that register is empty or its result is being taken.
  assign out_load = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || out_load;
  assign in_take = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      m1_q <= in_i.meas_one;
      m2_q <= in_i.meas_two;
      m3_q <= in_i.meas_three;
      m4_q <= in_i.meas_four;
      m5_q <= in_i.meas_five;
    end
  end

  pms_guard #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_guard (
    .meas_one_i  (m1_q),
    .meas_two_i  (m2_q),
    .meas_three_i(m3_q),
    .meas_four_i (m4_q),
    .meas_five_i (m5_q),
    .guard_o     (guard)
  );

  pms_step u_step (
    .mode_i (mode_q),
    .guard_i(guard),
    .mode_o (mode_d)
  );

  // The stored mode doubles as the result payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mode_q      <= MODE_STARTUP;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        mode_q      <= mode_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.next_mode = mode_q;

  a_mode_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_load |=> $stable(mode_q))
    else $error("mode changed without an item");

  a_startup_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (mode_q == MODE_STARTUP) |=>
      (mode_q == MODE_SWING_UP) || (mode_q == MODE_UP_DOWN))
    else $error("startup left to an illegal mode");

  a_upright_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (mode_q == MODE_UP_RIGHT) |=> (mode_q == MODE_STARTUP))
    else $error("up-right did not return to startup");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q ##1 out_valid_q |-> $past(s1_valid_q))
    else $error("result appeared without a held item");

endmodule

[design/pms_guard.sv]
module pms_guard import pms_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 10
) (
  input  logic signed [DATA_WIDTH-1:0] meas_one_i,
  input  logic signed [DATA_WIDTH-1:0] meas_two_i,
  input  logic signed [DATA_WIDTH-1:0] meas_three_i,
  input  logic signed [DATA_WIDTH-1:0] meas_four_i,
  input  logic signed [DATA_WIDTH-1:0] meas_five_i,
  output guard_t                       guard_o
);

  // "at most" thresholds are floored, "at least" thresholds are ceiled, so the
  // raw-magnitude compare matches the exact rational compare.
  localparam longint unsigned Deg20Le  = ((64'd20 * DegNum) << FRAC_BITS) / DegDen;
  localparam longint unsigned Deg20Ge  =
    (((64'd20 * DegNum) << FRAC_BITS) + DegDen - 64'd1) / DegDen;
  localparam longint unsigned Deg15Le  = ((64'd15 * DegNum) << FRAC_BITS) / DegDen;
  localparam longint unsigned Deg89Ge  =
    (((64'd89 * DegNum) << FRAC_BITS) + DegDen - 64'd1) / DegDen;
  localparam longint unsigned Deg91Le  = ((64'd91 * DegNum) << FRAC_BITS) / DegDen;
  localparam longint unsigned Deg1Le   = ((64'd1 * DegNum) << FRAC_BITS) / DegDen;
  localparam longint unsigned Deg35Le  = ((64'd35 * DegNum) << FRAC_BITS) / DegDen;
  localparam longint unsigned Deg60Ge  =
    (((64'd60 * DegNum) << FRAC_BITS) + DegDen - 64'd1) / DegDen;
  localparam longint unsigned Deg120Le = ((64'd120 * DegNum) << FRAC_BITS) / DegDen;
  localparam longint unsigned Deg10Le  = ((64'd10 * DegNum) << FRAC_BITS) / DegDen;
  localparam longint unsigned Deg170Ge =
    (((64'd170 * DegNum) << FRAC_BITS) + DegDen - 64'd1) / DegDen;
  localparam longint unsigned TenthLe  = (64'd1 << FRAC_BITS) / 64'd10;
  localparam longint unsigned P4Le     = (64'd4 << FRAC_BITS) / 64'd10;
  localparam longint unsigned Int2Le   = 64'd2 << FRAC_BITS;
  localparam longint unsigned Int7Le   = 64'd7 << FRAC_BITS;
  localparam longint unsigned Int10Le  = 64'd10 << FRAC_BITS;
  localparam longint unsigned Int20Le  = 64'd20 << FRAC_BITS;

  localparam int MagW = DATA_WIDTH + 1;

  function automatic logic [MagW-1:0] magnitude(input logic [DATA_WIDTH-1:0] raw);
    logic [MagW-1:0] ext;
    ext = {raw[DATA_WIDTH-1], raw};
    return raw[DATA_WIDTH-1] ? (~ext + MagW'(1)) : ext;
  endfunction

  logic [MagW-1:0] a1, a2, a3, a4, a5;
  longint unsigned w1, w2, w3, w4, w5;

  assign a1 = magnitude(meas_one_i);
  assign a2 = magnitude(meas_two_i);
  assign a3 = magnitude(meas_three_i);
  assign a4 = magnitude(meas_four_i);
  assign a5 = magnitude(meas_five_i);

  assign w1 = 64'(a1);
  assign w2 = 64'(a2);
  assign w3 = 64'(a3);
  assign w4 = 64'(a4);
  assign w5 = 64'(a5);

  always_comb begin
    guard_o.a1_le20     = w1 <= Deg20Le;
    guard_o.a1_ge20     = w1 >= Deg20Ge;
    guard_o.a1_le15     = w1 <= Deg15Le;
    guard_o.a1_ge89     = w1 >= Deg89Ge;
    guard_o.a1_le91     = w1 <= Deg91Le;
    guard_o.a1_le1      = w1 <= Deg1Le;
    guard_o.a1_le35     = w1 <= Deg35Le;
    guard_o.a1_ge60     = w1 >= Deg60Ge;
    guard_o.a1_le120    = w1 <= Deg120Le;
    guard_o.a1_le_tenth = w1 <= TenthLe;
    guard_o.a2_le10     = w2 <= Deg10Le;
    guard_o.a2_le15     = w2 <= Deg15Le;
    guard_o.a2_le1      = w2 <= Deg1Le;
    guard_o.a2_ge170    = w2 >= Deg170Ge;
    guard_o.a3_le1      = w3 <= Deg1Le;
    guard_o.a4_le2      = w4 <= Int2Le;
    guard_o.a4_le_0p4   = w4 <= P4Le;
    guard_o.a4_le20     = w4 <= Int20Le;
    guard_o.a5_le7      = w5 <= Int7Le;
    guard_o.a5_le10     = w5 <= Int10Le;
  end

endmodule

[design/pms_step.sv]
module pms_step import pms_pkg::*; (
  input  mode_e  mode_i,
  input  guard_t guard_i,
  output mode_e  mode_o
);

  always_comb begin
    mode_o = mode_i;
    unique case (mode_i)
      MODE_STARTUP: begin
        // The one guard sends every sample to up-down or swing-up: balance is never entered directly.
        mode_o = guard_i.a1_le20 ? MODE_UP_DOWN : MODE_SWING_UP;
      end
      MODE_SWING_UP: begin
        priority if (guard_i.a1_le20) mode_o = MODE_UP_DOWN;
        else if (guard_i.a1_ge89 && guard_i.a1_le91) mode_o = MODE_ARM_CORR;
        else if (guard_i.a1_le15 && guard_i.a2_le10) mode_o = MODE_BALANCE;
        else mode_o = mode_i;
      end
      MODE_UP_DOWN: begin
        priority if (guard_i.a2_le10 && guard_i.a4_le2 && guard_i.a5_le7) begin
          mode_o = MODE_BALANCE;
        end else if (!guard_i.a1_le20) begin
          mode_o = MODE_SWING_UP;
        end else if (guard_i.a1_le_tenth && guard_i.a4_le_0p4 &&
                     guard_i.a2_ge170 && guard_i.a5_le10) begin
          mode_o = MODE_COMPLIANT;
        end else begin
          mode_o = mode_i;
        end
      end
      MODE_BALANCE: begin
        priority if (!guard_i.a1_le20) begin
          mode_o = MODE_SWING_UP;
        end else if (guard_i.a1_le1 && guard_i.a2_le1 && guard_i.a3_le1) begin
          mode_o = MODE_UP_RIGHT;
        end else if (!guard_i.a1_ge20 && !guard_i.a2_le15) begin
          mode_o = MODE_UP_DOWN;
        end else begin
          mode_o = mode_i;
        end
      end
      MODE_ARM_CORR: begin
        priority if (guard_i.a1_le15 && guard_i.a2_le10) begin
          mode_o = MODE_BALANCE;
        end else if (!guard_i.a1_ge60 || !guard_i.a1_le120) begin
          mode_o = MODE_SWING_UP;
        end else begin
          mode_o = mode_i;
        end
      end
      MODE_COMPLIANT: begin
        if (!guard_i.a1_le35 || !guard_i.a4_le20) mode_o = MODE_UP_DOWN;
      end
      default: begin
        // Up-right and the unused code fall back to startup.
        mode_o = MODE_STARTUP;
      end
    endcase
  end

endmodule
